/* rtl/bvs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bit vector store package
// Request codes, item and result records, and sequencer states shared by
// the front, queue and back of the bit vector store.
// ----------------------------------------------------------------------------
package bvs_pkg;

  localparam int unsigned IDX_W       = 12;
  localparam int unsigned CNT_W       = 13;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [CNT_W-1:0] SIZE_RESET = 13'd4096;

  typedef enum logic [1:0] {
    REQ_WRITE = 2'd0,
    REQ_READ  = 2'd1,
    REQ_SCAN  = 2'd2,
    REQ_FILL  = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_REPLY
  } back_state_e;

  // Item after classification by the front
  typedef struct packed {
    req_e             req;
    logic [IDX_W-1:0] idx;
    logic             value;
    logic             err;
  } item_t;

  typedef struct packed {
    logic             bit_value;
    logic [CNT_W-1:0] found_index;
    logic [CNT_W-1:0] ones_count;
    logic             is_empty;
    logic             index_error;
  } result_t;

endpackage

/* rtl/bvs_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bit vector store front
// Classifies an incoming item: range check against the active length and
// word index of the addressed bit by reciprocal multiplication.
// ----------------------------------------------------------------------------
module bvs_front #(
  parameter int unsigned WORD_BITS = 64,
  parameter int unsigned WW        = 6
) (
  input  logic [1:0]                  req_type_i,
  input  logic [bvs_pkg::IDX_W-1:0]   index_i,
  input  logic                        value_i,
  input  logic [bvs_pkg::CNT_W-1:0]   len_i,
  output bvs_pkg::item_t              item_o,
  output logic [WW-1:0]               word_o
);

  // Exact quotient for any 12-bit index: K = index bits + log2 of divisor
  localparam int unsigned LW    = $clog2(WORD_BITS);
  localparam int unsigned K     = bvs_pkg::IDX_W + LW;
  localparam int unsigned RECIP = ((1 << K) + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned PW    = bvs_pkg::IDX_W + K + 1;

  logic [PW-1:0] prod;
  logic          idx_past_end;
  bvs_pkg::req_e req;

  assign req          = bvs_pkg::req_e'(req_type_i);
  assign prod         = PW'(index_i) * PW'(RECIP);
  assign word_o       = WW'(prod >> K);
  assign idx_past_end = {1'b0, index_i} >= len_i;

  always_comb begin
    item_o.req   = req;
    item_o.idx   = index_i;
    item_o.value = value_i;
    // fill ignores the index
    item_o.err   = (req != bvs_pkg::REQ_FILL) && idx_past_end;
  end

endmodule

/* rtl/bvs_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bit vector store queue
// Short FIFO that decouples the classifying front from the back sequencer.
// ----------------------------------------------------------------------------
module bvs_queue #(
  parameter int unsigned DW = 22
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  logic [DW-1:0] data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic [DW-1:0] data_o,
  output logic          empty_o
);

  localparam int unsigned DEPTH = bvs_pkg::QUEUE_DEPTH;
  localparam int unsigned PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW    = $clog2(DEPTH + 1);

  logic [DW-1:0] slot_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] count_q, count_d;
  logic          do_push, do_pop;

  assign full_o  = count_q == CW'(DEPTH);
  assign empty_o = count_q == '0;
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign data_o  = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

/* rtl/bvs_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bit vector store back
// Word memory, ones counter and sequencer that executes bit writes, bit
// reads, upward scans and fill/clear sweeps; holds the result register.
// ----------------------------------------------------------------------------
module bvs_back #(
  parameter int unsigned MAX_BITS  = 4096,
  parameter int unsigned WORD_BITS = 64,
  parameter int unsigned WW        = 6
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  input  logic [bvs_pkg::CNT_W-1:0]   cfg_data_i,
  input  logic                        q_empty_i,
  input  bvs_pkg::item_t              q_item_i,
  input  logic [WW-1:0]               q_word_i,
  output logic                        q_pop_o,
  output logic [bvs_pkg::CNT_W-1:0]   len_o,
  output logic                        clearing_o,
  output bvs_pkg::result_t            res_o,
  output logic                        res_valid_o,
  input  logic                        pop_i
);

  localparam int unsigned CW         = bvs_pkg::CNT_W;
  localparam int unsigned WORD_COUNT = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned OB         = $clog2(WORD_BITS);
  localparam int unsigned BW_RAW     = $clog2((WORD_COUNT + 1) * WORD_BITS + 1);
  localparam int unsigned BW         = (BW_RAW > CW + 1) ? BW_RAW : CW + 1;

  bvs_pkg::back_state_e state_q, state_d;
  logic [CW-1:0]        size_q, size_d;
  logic [CW-1:0]        ones_q, ones_d;
  logic [WW-1:0]        cur_q, cur_d;
  logic [BW-1:0]        base_q, base_d;
  logic [OB-1:0]        off_q, off_d;
  bvs_pkg::item_t       item_q, item_d;
  logic                 first_q, first_d;
  logic                 fill_v_q, fill_v_d;
  logic                 reply_q, reply_d;
  bvs_pkg::result_t     res_q, res_d;
  logic                 res_valid_q, res_valid_d;

  logic [WORD_BITS-1:0] mem_q [WORD_COUNT];
  logic [WORD_BITS-1:0] rdata_q;
  logic                 wr_en;
  logic [WW-1:0]        wr_addr, rd_addr;
  logic [WORD_BITS-1:0] wr_data;

  logic [CW-1:0]        len;
  logic [BW-1:0]        len_x, lim, head_base;
  logic [OB-1:0]        head_off;
  logic [WORD_BITS-1:0] lim_mask, low_mask, cand, bit_sel, sought;
  logic [OB-1:0]        enc;
  logic                 hit, last, old_bit, out_free;
  logic [CW-1:0]        ones_wr;

  function automatic bvs_pkg::result_t make_result(
    logic bit_v, logic [CW-1:0] found, logic [CW-1:0] ones, logic err);
    bvs_pkg::result_t r;
    r.bit_value   = bit_v;
    r.found_index = found;
    r.ones_count  = ones;
    r.is_empty    = ones == '0;
    r.index_error = err;
    return r;
  endfunction

  // saturate the configured length to the store size
  assign len         = (int'(size_q) > MAX_BITS) ? CW'(MAX_BITS) : size_q;
  assign len_o       = len;
  assign len_x       = BW'(len);
  assign clearing_o  = (state_q == bvs_pkg::ST_SWEEP) && !reply_q;
  assign res_o       = res_q;
  assign res_valid_o = res_valid_q;
  assign out_free    = ~res_valid_q | pop_i;

  assign head_base = BW'(q_word_i) * BW'(WORD_BITS);
  assign head_off  = OB'(BW'(q_item_i.idx) - head_base);

  // bits of the current word that lie below the length
  assign lim = len_x - base_q;
  always_comb begin
    if (base_q >= len_x) begin
      lim_mask = '0;
    end else if (lim >= BW'(WORD_BITS)) begin
      lim_mask = '1;
    end else begin
      lim_mask = ~({WORD_BITS{1'b1}} << lim[OB-1:0]);
    end
  end

  assign low_mask = first_q ? ({WORD_BITS{1'b1}} << off_q) : '1;
  assign sought   = item_q.value ? rdata_q : ~rdata_q;
  assign cand     = sought & lim_mask & low_mask;
  assign hit      = |cand;
  assign last     = (base_q + BW'(WORD_BITS)) >= len_x;

  // lowest matching bit
  always_comb begin
    enc = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (cand[i]) begin
        enc = OB'(i);
      end
    end
  end

  assign bit_sel = {{(WORD_BITS-1){1'b0}}, 1'b1} << off_q;
  assign old_bit = rdata_q[off_q];
  assign ones_wr = item_q.value ? ones_q + CW'(1) : ones_q - CW'(1);

  always_comb begin
    state_d     = state_q;
    size_d      = size_q;
    ones_d      = ones_q;
    cur_d       = cur_q;
    base_d      = base_q;
    off_d       = off_q;
    item_d      = item_q;
    first_d     = first_q;
    fill_v_d    = fill_v_q;
    reply_d     = reply_q;
    res_d       = res_q;
    res_valid_d = res_valid_q & ~pop_i;
    q_pop_o     = 1'b0;
    wr_en       = 1'b0;
    wr_addr     = cur_q;
    wr_data     = rdata_q;
    rd_addr     = cur_q;

    unique case (state_q)
      bvs_pkg::ST_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          item_d  = q_item_i;
          cur_d   = q_word_i;
          base_d  = head_base;
          off_d   = head_off;
          first_d = 1'b1;
          rd_addr = q_word_i;
          if (q_item_i.req == bvs_pkg::REQ_FILL) begin
            state_d  = bvs_pkg::ST_SWEEP;
            cur_d    = '0;
            base_d   = '0;
            fill_v_d = q_item_i.value;
            reply_d  = 1'b1;
          end else if (q_item_i.err) begin
            state_d = bvs_pkg::ST_REPLY;
          end else if (q_item_i.req == bvs_pkg::REQ_SCAN) begin
            state_d = bvs_pkg::ST_SCAN;
          end else begin
            state_d = bvs_pkg::ST_EXEC;
          end
        end
      end

      bvs_pkg::ST_EXEC: begin
        if (out_free) begin
          state_d     = bvs_pkg::ST_IDLE;
          res_valid_d = 1'b1;
          if (item_q.req == bvs_pkg::REQ_WRITE) begin
            res_d = make_result(1'b0, '0, ones_q, 1'b0);
            if (old_bit != item_q.value) begin
              wr_en   = 1'b1;
              wr_data = item_q.value ? (rdata_q | bit_sel) : (rdata_q & ~bit_sel);
              ones_d  = ones_wr;
              res_d   = make_result(1'b0, '0, ones_wr, 1'b0);
            end
          end else begin
            res_d = make_result(old_bit, '0, ones_q, 1'b0);
          end
        end
      end

      bvs_pkg::ST_SCAN: begin
        if (hit || last) begin
          // hold the read address so the word stays while the output stalls
          if (out_free) begin
            state_d     = bvs_pkg::ST_IDLE;
            res_valid_d = 1'b1;
            res_d       = make_result(1'b0, hit ? CW'(base_q + BW'(enc)) : len,
                                      ones_q, 1'b0);
          end
        end else begin
          cur_d   = cur_q + WW'(1);
          base_d  = base_q + BW'(WORD_BITS);
          first_d = 1'b0;
          rd_addr = cur_q + WW'(1);
        end
      end

      bvs_pkg::ST_SWEEP: begin
        wr_en   = 1'b1;
        wr_data = fill_v_q ? lim_mask : '0;
        cur_d   = cur_q + WW'(1);
        base_d  = base_q + BW'(WORD_BITS);
        if (cur_q == WW'(WORD_COUNT - 1)) begin
          ones_d  = fill_v_q ? len : '0;
          state_d = reply_q ? bvs_pkg::ST_REPLY : bvs_pkg::ST_IDLE;
        end
      end

      bvs_pkg::ST_REPLY: begin
        if (out_free) begin
          state_d     = bvs_pkg::ST_IDLE;
          res_valid_d = 1'b1;
          res_d       = make_result(1'b0,
                                    (item_q.req == bvs_pkg::REQ_SCAN) ? len : '0,
                                    ones_q, item_q.err);
        end
      end

      default: begin
        state_d = bvs_pkg::ST_IDLE;
      end
    endcase

    // a new length restarts the clearing pass
    if (cfg_valid_i) begin
      size_d   = cfg_data_i;
      state_d  = bvs_pkg::ST_SWEEP;
      cur_d    = '0;
      base_d   = '0;
      fill_v_d = 1'b0;
      reply_d  = 1'b0;
      ones_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bvs_pkg::ST_SWEEP;
      size_q      <= bvs_pkg::SIZE_RESET;
      ones_q      <= '0;
      cur_q       <= '0;
      base_q      <= '0;
      first_q     <= 1'b0;
      fill_v_q    <= 1'b0;
      reply_q     <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      size_q      <= size_d;
      ones_q      <= ones_d;
      cur_q       <= cur_d;
      base_q      <= base_d;
      first_q     <= first_d;
      fill_v_q    <= fill_v_d;
      reply_q     <= reply_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    off_q  <= off_d;
    res_q  <= res_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rdata_q <= mem_q[rd_addr];
  end

  a_ones_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ones_q <= len)
    else $error("ones count exceeds active length");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == bvs_pkg::ST_SCAN |-> !item_q.err)
    else $error("scan walking for an out-of-range item");

  a_write_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (state_q == bvs_pkg::ST_EXEC || state_q == bvs_pkg::ST_SWEEP))
    else $error("store written outside write or sweep");

  a_found_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> res_q.found_index <= len)
    else $error("found index beyond active length");

endmodule

/* rtl/bit_vector_store_with_scan.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bit vector store with scan
// Bit vector with single-bit write/read, upward scan for a value, fill,
// running ones count and empty flag, kept in a word-wide memory.
// ----------------------------------------------------------------------------
// Path push to result: write, read and out-of-range items are popped in idle and
// answered from execute or reply; a scan walks the words upward from the start
// word to a match or the last word; a fill sweeps every word, then replies.
// Bit writes and reads are handled one item at a time: the memory read is issued
// as the back sequencer pops the item, then its execute step answers it.
// After reset and after each size write a clearing pass zeroes the memory; full
// stays high meanwhile.
module bit_vector_store_with_scan #(
  parameter int unsigned MAX_BITS  = 4096,
  parameter int unsigned WORD_BITS = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [bvs_pkg::CNT_W-1:0]   cfg_data_i,
  input  logic                        push,
  output logic                        full,
  input  logic [1:0]                  req_type_i,
  input  logic [bvs_pkg::IDX_W-1:0]   index_i,
  input  logic                        value_i,
  output logic                        empty,
  input  logic                        pop,
  output logic                        bit_value_o,
  output logic [bvs_pkg::CNT_W-1:0]   found_index_o,
  output logic [bvs_pkg::CNT_W-1:0]   ones_count_o,
  output logic                        is_empty_o,
  output logic                        index_error_o
);

  localparam int unsigned WORD_COUNT = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned WW         = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int unsigned IW         = $bits(bvs_pkg::item_t);
  localparam int unsigned DW         = IW + WW;

  bvs_pkg::item_t              f_item, q_item;
  logic [WW-1:0]               f_word, q_word;
  logic [DW-1:0]               q_data;
  logic                        q_full, q_empty, q_pop, clearing, res_valid;
  logic [bvs_pkg::CNT_W-1:0]   len;
  bvs_pkg::result_t            res;

  assign cfg_ready_o = 1'b1;
  // hold off new items while the memory is being cleared
  assign full        = q_full | clearing;

  bvs_front #(
    .WORD_BITS (WORD_BITS),
    .WW        (WW)
  ) u_front (
    .req_type_i (req_type_i),
    .index_i    (index_i),
    .value_i    (value_i),
    .len_i      (len),
    .item_o     (f_item),
    .word_o     (f_word)
  );

  bvs_queue #(
    .DW (DW)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push & ~full),
    .data_i  ({f_word, f_item}),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_data),
    .empty_o (q_empty)
  );

  assign q_item = bvs_pkg::item_t'(q_data[IW-1:0]);
  assign q_word = q_data[IW +: WW];

  bvs_back #(
    .MAX_BITS  (MAX_BITS),
    .WORD_BITS (WORD_BITS),
    .WW        (WW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .q_empty_i   (q_empty),
    .q_item_i    (q_item),
    .q_word_i    (q_word),
    .q_pop_o     (q_pop),
    .len_o       (len),
    .clearing_o  (clearing),
    .res_o       (res),
    .res_valid_o (res_valid),
    .pop_i       (pop)
  );

  assign empty         = ~res_valid;
  assign bit_value_o   = res.bit_value;
  assign found_index_o = res.found_index;
  assign ones_count_o  = res.ones_count;
  assign is_empty_o    = res.is_empty;
  assign index_error_o = res.index_error;

endmodule

/* sim/tb_bit_vector_store_with_scan.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bit vector store with scan testbench
// Drives write, read, scan and fill requests under several vector lengths.
// Random idling and stalls run on both queue sides, plus a long receiver
// hold-off. Every result is checked against a local bitset shadow.
// ----------------------------------------------------------------------------
module tb_bit_vector_store_with_scan;

  localparam int unsigned CNT_W       = bvs_pkg::CNT_W;
  localparam int unsigned IDX_W       = bvs_pkg::IDX_W;
  localparam int unsigned VEC_MAX     = 4096;
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned CHUNK_ITEMS = 104;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  logic [CNT_W-1:0] cfg_data_i;
  logic             push;
  logic             full;
  logic [1:0]       req_type_i;
  logic [IDX_W-1:0] index_i;
  logic             value_i;
  logic             empty;
  logic             pop;
  logic             bit_value_o;
  logic [CNT_W-1:0] found_index_o;
  logic [CNT_W-1:0] ones_count_o;
  logic             is_empty_o;
  logic             index_error_o;

  // Shadow of the bitset
  bit               shadow_bits [VEC_MAX];
  int unsigned      shadow_ones;
  logic [CNT_W-1:0] shadow_size;

  bvs_pkg::result_t pending_answers [$];
  int unsigned error_count;
  int unsigned answers_checked;
  int unsigned sizes_applied;
  int unsigned req_counts [4];
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned hold_off_request;

  int unsigned send_pct_by_phase [4] = '{0, 70, 0, 18};
  int unsigned recv_pct_by_phase [4] = '{0, 0, 70, 18};

  bit_vector_store_with_scan u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .push          (push),
    .full          (full),
    .req_type_i    (req_type_i),
    .index_i       (index_i),
    .value_i       (value_i),
    .empty         (empty),
    .pop           (pop),
    .bit_value_o   (bit_value_o),
    .found_index_o (found_index_o),
    .ones_count_o  (ones_count_o),
    .is_empty_o    (is_empty_o),
    .index_error_o (index_error_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic int unsigned active_length();
    return (shadow_size > VEC_MAX) ? VEC_MAX : 32'(shadow_size);
  endfunction

  function automatic void clear_shadow();
    for (int unsigned p = 0; p < VEC_MAX; p++) shadow_bits[p] = 1'b0;
    shadow_ones = 0;
  endfunction

  // Apply one request to the shadow and return the answer it yields
  function automatic bvs_pkg::result_t compute_answer(bvs_pkg::req_e r,
                                                      logic [IDX_W-1:0] idx,
                                                      logic v);
    bvs_pkg::result_t ans;
    int unsigned      len;
    int unsigned      p;
    ans = '0;
    len = active_length();
    case (r)
      bvs_pkg::REQ_WRITE: begin
        if (idx >= len) begin
          ans.index_error = 1'b1;
        end else if (shadow_bits[idx] != v) begin
          shadow_bits[idx] = v;
          if (v) shadow_ones++;
          else shadow_ones--;
        end
      end
      bvs_pkg::REQ_READ: begin
        if (idx >= len) ans.index_error = 1'b1;
        else ans.bit_value = shadow_bits[idx];
      end
      bvs_pkg::REQ_SCAN: begin
        ans.found_index = CNT_W'(len);
        if (idx >= len) begin
          ans.index_error = 1'b1;
        end else begin
          for (p = 32'(idx); p < len; p++) begin
            if (shadow_bits[p] == v) begin
              ans.found_index = CNT_W'(p);
              break;
            end
          end
        end
      end
      default: begin
        for (p = 0; p < VEC_MAX; p++) shadow_bits[p] = v && (p < len);
        shadow_ones = v ? len : 0;
      end
    endcase
    ans.ones_count = CNT_W'(shadow_ones);
    ans.is_empty   = (shadow_ones == 0);
    return ans;
  endfunction

  task automatic report_mismatch(string what, logic [CNT_W-1:0] got,
                                 logic [CNT_W-1:0] want);
    error_count++;
    if (error_count <= 40)
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  task automatic check_answer();
    bvs_pkg::result_t want;
    if (pending_answers.size() == 0) begin
      report_mismatch("unexpected result", ones_count_o, '0);
      return;
    end
    want = pending_answers.pop_front();
    if (bit_value_o !== want.bit_value)
      report_mismatch("bit_value", CNT_W'(bit_value_o), CNT_W'(want.bit_value));
    if (found_index_o !== want.found_index)
      report_mismatch("found_index", found_index_o, want.found_index);
    if (ones_count_o !== want.ones_count)
      report_mismatch("ones_count", ones_count_o, want.ones_count);
    if (is_empty_o !== want.is_empty)
      report_mismatch("is_empty", CNT_W'(is_empty_o), CNT_W'(want.is_empty));
    if (index_error_o !== want.index_error)
      report_mismatch("index_error", CNT_W'(index_error_o), CNT_W'(want.index_error));
    answers_checked++;
  endtask

  // Result side: check on every accepted item, stall at random, honor hold-offs
  initial begin : result_checker
    int unsigned hold_left;
    hold_left = 0;
    pop <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && pop && !empty) check_answer();
      if (hold_off_request != 0) begin
        hold_left        = hold_off_request;
        hold_off_request = 0;
      end
      if (!rst_ni) begin
        pop <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (push && !full) || (pop && !empty) || (cfg_valid_i && cfg_ready_o))
        quiet = 0;
      else
        quiet++;
    end
    $display("[%0t] watchdog: no handshake for %0d cycles", $time, STALL_LIMIT);
    $display("bit_vector_store_with_scan regression: fail");
    $finish;
  end

  task automatic send_item(bvs_pkg::req_e r, logic [IDX_W-1:0] idx, logic v);
    int unsigned gap;
    gap = 0;
    if ($urandom_range(0, 99) < send_idle_pct) gap = $urandom_range(1, 6);
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push       <= 1'b1;
    req_type_i <= r;
    index_i    <= idx;
    value_i    <= v;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    pending_answers.push_back(compute_answer(r, idx, v));
    req_counts[r]++;
  endtask

  task automatic wait_drained();
    if (push) push <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk_i);
  endtask

  // Length writes only on an idle block; a new length clears the vector
  task automatic write_size(logic [CNT_W-1:0] sz);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= sz;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    shadow_size = sz;
    clear_shadow();
    sizes_applied++;
    @(posedge clk_i);
  endtask

  task automatic send_random_item();
    int unsigned      roll;
    int unsigned      len;
    bvs_pkg::req_e    r;
    logic [IDX_W-1:0] idx;
    logic             v;
    len  = active_length();
    roll = $urandom_range(0, 99);
    if (roll < 40) r = bvs_pkg::REQ_WRITE;
    else if (roll < 65) r = bvs_pkg::REQ_READ;
    else if (roll < 96) r = bvs_pkg::REQ_SCAN;
    else r = bvs_pkg::REQ_FILL;
    v = 1'($urandom_range(0, 1));
    // mostly in-range positions, a few past the end
    if (len == 0 || (len < VEC_MAX && $urandom_range(0, 99) < 8))
      idx = IDX_W'($urandom_range(len, VEC_MAX - 1));
    else
      idx = IDX_W'($urandom_range(0, len - 1));
    send_item(r, idx, v);
  endtask

  task automatic test_directed();
    send_item(bvs_pkg::REQ_WRITE, 12'd0, 1'b1);
    send_item(bvs_pkg::REQ_WRITE, 12'd4095, 1'b1);
    send_item(bvs_pkg::REQ_READ, 12'd0, 1'b0);
    send_item(bvs_pkg::REQ_READ, 12'd4095, 1'b0);
    send_item(bvs_pkg::REQ_READ, 12'd1, 1'b1);
    send_item(bvs_pkg::REQ_SCAN, 12'd0, 1'b1);
    send_item(bvs_pkg::REQ_SCAN, 12'd1, 1'b1);
    send_item(bvs_pkg::REQ_SCAN, 12'd0, 1'b0);
    send_item(bvs_pkg::REQ_SCAN, 12'd4095, 1'b0);
    send_item(bvs_pkg::REQ_WRITE, 12'd0, 1'b0);
    send_item(bvs_pkg::REQ_WRITE, 12'd0, 1'b0);
    send_item(bvs_pkg::REQ_FILL, 12'd4095, 1'b1);
    send_item(bvs_pkg::REQ_SCAN, 12'd0, 1'b0);
    send_item(bvs_pkg::REQ_FILL, 12'd0, 1'b0);
    send_item(bvs_pkg::REQ_SCAN, 12'd0, 1'b1);
    // one-bit vector: everything past bit zero is out of range
    write_size(13'd1);
    send_item(bvs_pkg::REQ_WRITE, 12'd0, 1'b1);
    send_item(bvs_pkg::REQ_WRITE, 12'd1, 1'b1);
    send_item(bvs_pkg::REQ_READ, 12'd4095, 1'b1);
    send_item(bvs_pkg::REQ_SCAN, 12'd0, 1'b0);
    send_item(bvs_pkg::REQ_FILL, 12'd0, 1'b1);
    // zero length: no bits at all, scan answers zero
    write_size(13'd0);
    send_item(bvs_pkg::REQ_WRITE, 12'd0, 1'b1);
    send_item(bvs_pkg::REQ_SCAN, 12'd0, 1'b0);
    send_item(bvs_pkg::REQ_FILL, 12'd0, 1'b1);
    // length above the maximum saturates
    write_size(13'h1FFF);
    send_item(bvs_pkg::REQ_WRITE, 12'd4095, 1'b1);
    send_item(bvs_pkg::REQ_FILL, 12'd7, 1'b1);
    // word-multiple length fills its last word completely
    write_size(13'd64);
    send_item(bvs_pkg::REQ_FILL, 12'd0, 1'b1);
    send_item(bvs_pkg::REQ_SCAN, 12'd63, 1'b0);
    send_item(bvs_pkg::REQ_READ, 12'd64, 1'b1);
    write_size(bvs_pkg::SIZE_RESET);
  endtask

  task automatic test_random_phases();
    logic [CNT_W-1:0] sz;
    for (int phase = 0; phase < 4; phase++) begin
      for (int chunk = 0; chunk < 3; chunk++) begin
        case (chunk)
          0:       sz = CNT_W'(VEC_MAX);
          1:       sz = CNT_W'($urandom_range(1, VEC_MAX));
          default: sz = $urandom_range(0, 1) ? CNT_W'(64 * $urandom_range(1, 3))
                                             : CNT_W'($urandom_range(1, 130));
        endcase
        write_size(sz);
        send_idle_pct  = send_pct_by_phase[phase];
        recv_stall_pct = recv_pct_by_phase[phase];
        // the first chunk of each later phase runs flat out on both sides
        if (chunk == 0 && phase != 0) begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        repeat (CHUNK_ITEMS) send_random_item();
      end
    end
  endtask

  // Hold the result side long enough that the block fills and stalls push
  task automatic test_backpressure();
    write_size(bvs_pkg::SIZE_RESET);
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    hold_off_request = 300;
    repeat (48) send_random_item();
    wait_drained();
    repeat (24) send_random_item();
    wait_drained();
  endtask

  initial begin
    rst_ni      <= 1'b0;
    push        <= 1'b0;
    req_type_i  <= bvs_pkg::REQ_WRITE;
    index_i     <= '0;
    value_i     <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_data_i  <= bvs_pkg::SIZE_RESET;
    error_count      = 0;
    answers_checked  = 0;
    sizes_applied    = 0;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    hold_off_request = 0;
    req_counts       = '{0, 0, 0, 0};
    shadow_size      = bvs_pkg::SIZE_RESET;
    clear_shadow();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_random_phases();
    test_backpressure();

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    wait_drained();
    // a fill sweeps every word; leave room for any stray result
    repeat (80) @(posedge clk_i);

    $display("Covered %0d requests (write %0d, read %0d, scan %0d, fill %0d) over %0d lengths",
             req_counts[bvs_pkg::REQ_WRITE] + req_counts[bvs_pkg::REQ_READ] +
             req_counts[bvs_pkg::REQ_SCAN] + req_counts[bvs_pkg::REQ_FILL],
             req_counts[bvs_pkg::REQ_WRITE], req_counts[bvs_pkg::REQ_READ],
             req_counts[bvs_pkg::REQ_SCAN], req_counts[bvs_pkg::REQ_FILL], sizes_applied);
    $display("%0d results compared, %0d mismatches", answers_checked, error_count);
    if (error_count == 0) begin
      $display("bit_vector_store_with_scan regression: pass");
    end else begin
      $display("bit_vector_store_with_scan regression: fail");
    end
    $finish;
  end

endmodule
